// ===== src/rvpa_pkg.sv =====
// Shared types, widths and register codes for the vector and point rotation block.
package rvpa_pkg;

    localparam int COORD_W   = 16;
    localparam int FRAC_BITS = 14;
    localparam int SLICE_W   = 16;
    localparam int REG_W     = 3 * SLICE_W;
    localparam int PADDR_W   = 6;
    localparam int PDATA_W   = 64;
    localparam int REG_IDX_W = 3;
    localparam int NUM_STG   = 7;

    localparam int AB_W      = COORD_W + 1;
    localparam int PROD_V_W  = COORD_W + SLICE_W;
    localparam int SUM_V_W   = PROD_V_W + 2;
    localparam int DOT_W     = AB_W + SLICE_W + 2;
    localparam int ADN_W     = DOT_W + SLICE_W;
    localparam int AD_W      = ADN_W + 1 - 2 * FRAC_BITS;
    localparam int DB_W      = AD_W + 1;
    localparam int PROD_D_W  = DB_W + SLICE_W;
    localparam int SUM_D_W   = PROD_D_W + 2;
    localparam int RP_W      = SUM_D_W + 3 - FRAC_BITS;

    localparam int COORD_MAX = 2 ** (COORD_W - 1) - 1;
    localparam int COORD_MIN = -COORD_MAX - 1;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_MATRIX_ROW_0   = 3'd0,
        REG_MATRIX_ROW_1   = 3'd1,
        REG_MATRIX_ROW_2   = 3'd2,
        REG_AXIS_POINT     = 3'd3,
        REG_AXIS_DIRECTION = 3'd4
    } t_reg_idx;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SLICE_W-1:0] t_slice;
    typedef logic [REG_W-1:0]          t_reg;

    typedef struct packed {
        logic   ovf;
        t_coord val;
    } t_sat;

    function automatic t_sat sat_coord(input logic signed [RP_W-1:0] x);
        t_sat s;
        s.ovf = 1'b0;
        s.val = COORD_W'(x);
        if (x > COORD_MAX) begin
            s.ovf = 1'b1;
            s.val = COORD_W'(COORD_MAX);
        end else if (x < COORD_MIN) begin
            s.ovf = 1'b1;
            s.val = COORD_W'(COORD_MIN);
        end
        return s;
    endfunction

endpackage

// ===== src/rvpa_in_if.sv =====
// Input channel carrying one free vector and one point per beat.
interface rvpa_in_if;
    import rvpa_pkg::*;

    logic   valid;
    logic   ready;
    t_coord vec_x;
    t_coord vec_y;
    t_coord vec_z;
    t_coord point_x;
    t_coord point_y;
    t_coord point_z;

    modport source (output valid, vec_x, vec_y, vec_z, point_x, point_y, point_z,
                    input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, point_x, point_y, point_z,
                    output ready);
endinterface

// ===== src/rvpa_out_if.sv =====
// Output channel carrying the rotated vector, the rotated point and the overflow flag.
interface rvpa_out_if;
    import rvpa_pkg::*;

    logic   valid;
    logic   ready;
    t_coord rot_vec_x;
    t_coord rot_vec_y;
    t_coord rot_vec_z;
    t_coord rot_point_x;
    t_coord rot_point_y;
    t_coord rot_point_z;
    logic   overflow;

    modport source (output valid, rot_vec_x, rot_vec_y, rot_vec_z,
                    rot_point_x, rot_point_y, rot_point_z, overflow, input ready);
    modport sink   (input valid, rot_vec_x, rot_vec_y, rot_vec_z,
                    rot_point_x, rot_point_y, rot_point_z, overflow, output ready);
endinterface

// ===== src/rotate_vector_and_point_about_axis.sv =====
// Seven-stage pipeline that rotates a free vector and a point about a configured axis.
// An accepted input beat moves through the r1 to r6 stage registers and the r_out registers to the output.
// Throughput is one beat per cycle; the whole pipeline holds only while the output waits.
// Each stage has at most one row of multipliers or one adder tree with rounding and clamping.
// Reset clears all valid bits, loads the identity matrix and zeroes axis point and direction.
module rotate_vector_and_point_about_axis (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [rvpa_pkg::PADDR_W-1:0] paddr,
    input  logic [rvpa_pkg::PDATA_W-1:0] pwdata,
    output logic [rvpa_pkg::PDATA_W-1:0] prdata,
    output logic                     pready,
    rvpa_in_if.sink                  i_item,
    rvpa_out_if.source               o_res
);
    import rvpa_pkg::*;

    t_reg r_mat_row [3];
    t_reg r_axis_pt;
    t_reg r_axis_dir;

    t_slice m_el [3][3];
    t_slice a_pt [3];
    t_slice n_dir [3];
    t_reg_idx w_idx;
    logic     w_en;

    logic [NUM_STG-1:0] r_vld;
    logic               en;

    t_coord                       in_v [3];
    t_coord                       in_p [3];
    t_coord                       r1_v [3];
    logic signed [AB_W-1:0]       r1_ab [3];
    logic signed [PROD_V_W-1:0]   r2_pv [3][3];
    logic signed [AB_W+SLICE_W-1:0] r2_pd [3];
    logic signed [AB_W-1:0]       r2_ab [3];
    t_coord                       r3_rv [3];
    logic                         r3_ovf;
    logic signed [DOT_W-1:0]      r3_dot;
    logic signed [AB_W-1:0]       r3_ab [3];
    logic signed [ADN_W-1:0]      r4_adn [3];
    logic signed [AB_W-1:0]       r4_ab [3];
    t_coord                       r4_rv [3];
    logic                         r4_ovf;
    logic signed [AD_W-1:0]       r5_ad [3];
    logic signed [DB_W-1:0]       r5_db [3];
    t_coord                       r5_rv [3];
    logic                         r5_ovf;
    logic signed [PROD_D_W-1:0]   r6_pd [3][3];
    logic signed [AD_W-1:0]       r6_ad [3];
    t_coord                       r6_rv [3];
    logic                         r6_ovf;
    t_coord                       r_out_vec [3];
    t_coord                       r_out_pt [3];
    logic                         r_out_ovf;

    t_sat                         n3_rv [3];
    logic                         n3_ovf;
    logic signed [DOT_W-1:0]      n3_dot;
    logic signed [AD_W-1:0]       n5_ad [3];
    logic signed [DB_W-1:0]       n5_db [3];
    t_sat                         n7_pt [3];
    logic                         n7_ovf;

    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:3]);
    assign w_en   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat_row[0] <= REG_W'(1 << FRAC_BITS);
            r_mat_row[1] <= REG_W'(1 << FRAC_BITS) << SLICE_W;
            r_mat_row[2] <= REG_W'(1 << FRAC_BITS) << (2 * SLICE_W);
            r_axis_pt    <= '0;
            r_axis_dir   <= '0;
        end else if (w_en) begin
            case (w_idx)
                REG_MATRIX_ROW_0:   r_mat_row[0] <= pwdata[REG_W-1:0];
                REG_MATRIX_ROW_1:   r_mat_row[1] <= pwdata[REG_W-1:0];
                REG_MATRIX_ROW_2:   r_mat_row[2] <= pwdata[REG_W-1:0];
                REG_AXIS_POINT:     r_axis_pt    <= pwdata[REG_W-1:0];
                REG_AXIS_DIRECTION: r_axis_dir   <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_MATRIX_ROW_0:   prdata = PDATA_W'(r_mat_row[0]);
            REG_MATRIX_ROW_1:   prdata = PDATA_W'(r_mat_row[1]);
            REG_MATRIX_ROW_2:   prdata = PDATA_W'(r_mat_row[2]);
            REG_AXIS_POINT:     prdata = PDATA_W'(r_axis_pt);
            REG_AXIS_DIRECTION: prdata = PDATA_W'(r_axis_dir);
            default:            prdata = '0;
        endcase
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                m_el[i][j] = $signed(r_mat_row[i][SLICE_W*j +: SLICE_W]);
            end
            a_pt[i]  = $signed(r_axis_pt[SLICE_W*i +: SLICE_W]);
            n_dir[i] = $signed(r_axis_dir[SLICE_W*i +: SLICE_W]);
        end
    end

    assign en           = !r_vld[NUM_STG-1] || o_res.ready;
    assign i_item.ready = en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NUM_STG-2:0], i_item.valid};
        end
    end

    assign in_v[0] = i_item.vec_x;
    assign in_v[1] = i_item.vec_y;
    assign in_v[2] = i_item.vec_z;
    assign in_p[0] = i_item.point_x;
    assign in_p[1] = i_item.point_y;
    assign in_p[2] = i_item.point_z;

    always_comb begin
        n3_ovf = 1'b0;
        n3_dot = '0;
        for (int i = 0; i < 3; i++) begin
            n3_rv[i] = sat_coord(RP_W'((SUM_V_W'(r2_pv[i][0]) + SUM_V_W'(r2_pv[i][1])
                + SUM_V_W'(r2_pv[i][2]) + SUM_V_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS));
            n3_ovf = n3_ovf | n3_rv[i].ovf;
            n3_dot = n3_dot + DOT_W'(r2_pd[i]);
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n5_ad[i] = AD_W'((ADN_W'(r4_adn[i]) + ADN_W'(1 << (2 * FRAC_BITS - 1)))
                >>> (2 * FRAC_BITS));
            n5_db[i] = DB_W'(r4_ab[i]) - DB_W'(n5_ad[i]);
        end
    end

    always_comb begin
        n7_ovf = r6_ovf;
        for (int i = 0; i < 3; i++) begin
            n7_pt[i] = sat_coord(RP_W'((SUM_D_W'(r6_pd[i][0]) + SUM_D_W'(r6_pd[i][1])
                + SUM_D_W'(r6_pd[i][2]) + SUM_D_W'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS)
                + RP_W'(a_pt[i]) + RP_W'(r6_ad[i]));
            n7_ovf = n7_ovf | n7_pt[i].ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_v[i]  <= in_v[i];
                r1_ab[i] <= AB_W'(in_p[i]) - AB_W'(a_pt[i]);

                for (int j = 0; j < 3; j++) begin
                    r2_pv[i][j] <= PROD_V_W'(m_el[i][j]) * PROD_V_W'(r1_v[j]);
                end
                r2_pd[i] <= (AB_W + SLICE_W)'(r1_ab[i]) * (AB_W + SLICE_W)'(n_dir[i]);
                r2_ab[i] <= r1_ab[i];

                r3_rv[i] <= n3_rv[i].val;
                r3_ab[i] <= r2_ab[i];

                r4_adn[i] <= ADN_W'(r3_dot) * ADN_W'(n_dir[i]);
                r4_ab[i]  <= r3_ab[i];
                r4_rv[i]  <= r3_rv[i];

                r5_ad[i] <= n5_ad[i];
                r5_db[i] <= n5_db[i];
                r5_rv[i] <= r4_rv[i];

                for (int j = 0; j < 3; j++) begin
                    r6_pd[i][j] <= PROD_D_W'(m_el[i][j]) * PROD_D_W'(r5_db[j]);
                end
                r6_ad[i] <= r5_ad[i];
                r6_rv[i] <= r5_rv[i];

                r_out_vec[i] <= r6_rv[i];
                r_out_pt[i]  <= n7_pt[i].val;
            end
            r3_ovf    <= n3_ovf;
            r3_dot    <= n3_dot;
            r4_ovf    <= r3_ovf;
            r5_ovf    <= r4_ovf;
            r6_ovf    <= r5_ovf;
            r_out_ovf <= n7_ovf;
        end
    end

    assign o_res.valid       = r_vld[NUM_STG-1];
    assign o_res.rot_vec_x   = r_out_vec[0];
    assign o_res.rot_vec_y   = r_out_vec[1];
    assign o_res.rot_vec_z   = r_out_vec[2];
    assign o_res.rot_point_x = r_out_pt[0];
    assign o_res.rot_point_y = r_out_pt[1];
    assign o_res.rot_point_z = r_out_pt[2];
    assign o_res.overflow    = r_out_ovf;

    a_rst_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(!i_rst_n) |-> r_vld == '0)
        else $error("Pipeline holds a valid beat right after reset.");

    a_ready_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_vld[NUM_STG-1] |-> i_item.ready)
        else $error("Input refused although the output stage is empty.");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_vld))
        else $error("Stage valid bits moved during a stall.");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item.valid && i_item.ready |=> r_vld[0])
        else $error("Accepted beat did not enter the first stage.");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_res.valid) |-> $past(r_vld[NUM_STG-2]))
        else $error("Output became valid without a beat in the stage before it.");

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the vector and point rotation pipeline with APB setup.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import rvpa_pkg::*;

    typedef struct {
        t_coord vec_x;
        t_coord vec_y;
        t_coord vec_z;
        t_coord point_x;
        t_coord point_y;
        t_coord point_z;
    } t_rotate_in;

    typedef struct {
        t_coord rot_vec_x;
        t_coord rot_vec_y;
        t_coord rot_vec_z;
        t_coord rot_point_x;
        t_coord rot_point_y;
        t_coord rot_point_z;
        logic   overflow;
    } t_rotate_out;

    localparam int UNMAPPED_IDX = 5;
    localparam int CHUNK_ITEMS  = 52;

    logic                i_clk   = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [PADDR_W-1:0]  paddr   = '0;
    logic [PDATA_W-1:0]  pwdata  = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    rvpa_in_if  in_ch ();
    rvpa_out_if out_ch ();

    rotate_vector_and_point_about_axis DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_item  (in_ch),
        .o_res   (out_ch)
    );

    t_reg        rot_rows [3];
    t_reg        pivot;
    t_reg        axis_dir;

    t_rotate_in  pending_items [$];
    t_rotate_out expected_results [$];
    t_rotate_in  cur_item;
    t_rotate_out want;
    t_rotate_out got;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          sender_hold    = 1'b0;
    int          errors         = 0;
    int          items_accepted = 0;
    int          results_checked = 0;
    int          overflow_results = 0;
    int          config_sets    = 0;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    initial begin
        #5_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic longint round_q(input longint x, input int sh);
        return (x + (longint'(1) << (sh - 1))) >>> sh;
    endfunction

    function automatic longint saturate(input longint x, input int bits, inout bit ovf);
        longint hi;
        longint lo;
        hi = (longint'(1) << (bits - 1)) - 1;
        lo = -hi - 1;
        if (x > hi) begin
            ovf = 1'b1;
            return hi;
        end
        if (x < lo) begin
            ovf = 1'b1;
            return lo;
        end
        return x;
    endfunction

    function automatic t_rotate_out rotate_item(input t_rotate_in it);
        longint r [3][3];
        longint v [3];
        longint p [3];
        longint a [3];
        longint n [3];
        longint ab [3];
        longint ad [3];
        longint db [3];
        longint rv [3];
        longint rp [3];
        longint acc;
        longint dot;
        bit ovf;
        t_rotate_out res;
        ovf = 1'b0;
        dot = 0;
        v[0] = it.vec_x;
        v[1] = it.vec_y;
        v[2] = it.vec_z;
        p[0] = it.point_x;
        p[1] = it.point_y;
        p[2] = it.point_z;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                r[i][j] = longint'($signed(rot_rows[i][SLICE_W*j +: SLICE_W]));
            end
            a[i] = longint'($signed(pivot[SLICE_W*i +: SLICE_W]));
            n[i] = longint'($signed(axis_dir[SLICE_W*i +: SLICE_W]));
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                acc += r[i][j] * v[j];
            end
            rv[i] = saturate(round_q(acc, FRAC_BITS), COORD_W, ovf);
        end
        for (int i = 0; i < 3; i++) begin
            ab[i] = p[i] - a[i];
            dot += ab[i] * n[i];
        end
        dot = saturate(dot, 48, ovf);
        for (int i = 0; i < 3; i++) begin
            ad[i] = round_q(dot * n[i], 2 * FRAC_BITS);
            db[i] = saturate(ab[i] - ad[i], 44, ovf);
        end
        for (int i = 0; i < 3; i++) begin
            acc = 0;
            for (int j = 0; j < 3; j++) begin
                acc += r[i][j] * db[j];
            end
            acc = round_q(acc, FRAC_BITS) + a[i] + ad[i];
            rp[i] = saturate(acc, COORD_W, ovf);
        end
        res.rot_vec_x   = t_coord'(rv[0]);
        res.rot_vec_y   = t_coord'(rv[1]);
        res.rot_vec_z   = t_coord'(rv[2]);
        res.rot_point_x = t_coord'(rp[0]);
        res.rot_point_y = t_coord'(rp[1]);
        res.rot_point_z = t_coord'(rp[2]);
        res.overflow    = ovf;
        return res;
    endfunction

    // Input driver: the predictor runs on each beat the block accepts.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid   <= 1'b0;
            in_ch.vec_x   <= '0;
            in_ch.vec_y   <= '0;
            in_ch.vec_z   <= '0;
            in_ch.point_x <= '0;
            in_ch.point_y <= '0;
            in_ch.point_z <= '0;
        end else begin
            if (in_ch.valid && in_ch.ready) begin
                expected_results.push_back(rotate_item(cur_item));
                items_accepted++;
            end
            if (!in_ch.valid || in_ch.ready) begin
                if (!sender_hold && pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= send_idle_pct) begin
                    cur_item = pending_items.pop_front();
                    in_ch.valid   <= 1'b1;
                    in_ch.vec_x   <= cur_item.vec_x;
                    in_ch.vec_y   <= cur_item.vec_y;
                    in_ch.vec_z   <= cur_item.vec_z;
                    in_ch.point_x <= cur_item.point_x;
                    in_ch.point_y <= cur_item.point_y;
                    in_ch.point_z <= cur_item.point_z;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_field(input string name, input longint exp_v, input longint act_v);
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
    endtask

    // Output monitor with random back-pressure.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got.rot_vec_x   = out_ch.rot_vec_x;
                got.rot_vec_y   = out_ch.rot_vec_y;
                got.rot_vec_z   = out_ch.rot_vec_z;
                got.rot_point_x = out_ch.rot_point_x;
                got.rot_point_y = out_ch.rot_point_y;
                got.rot_point_z = out_ch.rot_point_z;
                got.overflow    = out_ch.overflow;
                if (expected_results.size() == 0) begin
                    errors++;
                    $write("%0t: result beat with no expectation, expected none, actual",
                           $time);
                    $display(" %0d %0d %0d %0d %0d %0d %0d",
                             got.rot_vec_x, got.rot_vec_y, got.rot_vec_z,
                             got.rot_point_x, got.rot_point_y, got.rot_point_z, got.overflow);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.overflow) overflow_results++;
                    if (got.rot_vec_x !== want.rot_vec_x)
                        report_field("rot_vec_x", want.rot_vec_x, got.rot_vec_x);
                    if (got.rot_vec_y !== want.rot_vec_y)
                        report_field("rot_vec_y", want.rot_vec_y, got.rot_vec_y);
                    if (got.rot_vec_z !== want.rot_vec_z)
                        report_field("rot_vec_z", want.rot_vec_z, got.rot_vec_z);
                    if (got.rot_point_x !== want.rot_point_x)
                        report_field("rot_point_x", want.rot_point_x, got.rot_point_x);
                    if (got.rot_point_y !== want.rot_point_y)
                        report_field("rot_point_y", want.rot_point_y, got.rot_point_y);
                    if (got.rot_point_z !== want.rot_point_z)
                        report_field("rot_point_z", want.rot_point_z, got.rot_point_z);
                    if (got.overflow !== want.overflow)
                        report_field("overflow", want.overflow, got.overflow);
                end
            end
            out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    function automatic logic [PDATA_W-1:0] pack3(input int x, input int y, input int z);
        return {16'h0, z[15:0], y[15:0], x[15:0]};
    endfunction

    task automatic apb_write(input int idx, input logic [PDATA_W-1:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx * 8);
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (t_reg_idx'(idx))
            REG_MATRIX_ROW_0:   rot_rows[0] = data[REG_W-1:0];
            REG_MATRIX_ROW_1:   rot_rows[1] = data[REG_W-1:0];
            REG_MATRIX_ROW_2:   rot_rows[2] = data[REG_W-1:0];
            REG_AXIS_POINT:     pivot       = data[REG_W-1:0];
            REG_AXIS_DIRECTION: axis_dir    = data[REG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic wait_idle();
        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (NUM_STG + 2) @(posedge i_clk);
    endtask

    task automatic add_item(input int vx, input int vy, input int vz,
                            input int px, input int py, input int pz);
        t_rotate_in it;
        it.vec_x   = t_coord'(vx);
        it.vec_y   = t_coord'(vy);
        it.vec_z   = t_coord'(vz);
        it.point_x = t_coord'(px);
        it.point_y = t_coord'(py);
        it.point_z = t_coord'(pz);
        pending_items.push_back(it);
    endtask

    function automatic int rand_coord();
        case ($urandom_range(0, 9))
            0:       return 32767;
            1:       return -32768;
            2, 3:    return $urandom_range(0, 600) - 300;
            default: return int'($signed(16'($urandom())));
        endcase
    endfunction

    function automatic int rand_q14();
        case ($urandom_range(0, 19))
            0, 1:          return 0;
            2, 3:          return 16384;
            4:             return -16384;
            5:             return 11585;
            6:             return -11585;
            7, 8:          return 32767;
            9:             return -32768;
            10, 11, 12:    return $urandom_range(0, 4000) - 2000;
            default:       return int'($signed(16'($urandom())));
        endcase
    endfunction

    task automatic load_random_config();
        int s;
        for (int i = 0; i < 3; i++) begin
            apb_write(i, pack3(rand_q14(), rand_q14(), rand_q14()));
        end
        apb_write(REG_AXIS_POINT, pack3(rand_coord(), rand_coord(), rand_coord()));
        if ($urandom_range(0, 1)) begin
            s = $urandom_range(0, 1) ? 16384 : -16384;
            case ($urandom_range(0, 3))
                0:       apb_write(REG_AXIS_DIRECTION, pack3(s, 0, 0));
                1:       apb_write(REG_AXIS_DIRECTION, pack3(0, s, 0));
                2:       apb_write(REG_AXIS_DIRECTION, pack3(0, 0, s));
                default: apb_write(REG_AXIS_DIRECTION, pack3(11585, 0, -11585));
            endcase
        end else begin
            apb_write(REG_AXIS_DIRECTION, pack3(rand_q14(), rand_q14(), rand_q14()));
        end
        config_sets++;
    endtask

    initial begin
        rot_rows[0] = REG_W'(16384);
        rot_rows[1] = REG_W'(16384) << 16;
        rot_rows[2] = REG_W'(16384) << 32;
        pivot       = '0;
        axis_dir    = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: identity matrix and a zero axis.
        add_item(0, 0, 0, 0, 0, 0);
        add_item(32767, 32767, 32767, 32767, 32767, 32767);
        add_item(-32768, -32768, -32768, -32768, -32768, -32768);
        add_item(1, -1, 2, -2, 3, -3);
        add_item(32767, -32768, 0, -32768, 32767, 1);
        add_item(-1, -1, -1, -1, -1, -1);
        wait_idle();

        // Quarter turn about a z axis through an offset point.
        apb_write(REG_MATRIX_ROW_0, pack3(0, -16384, 0));
        apb_write(REG_MATRIX_ROW_1, pack3(16384, 0, 0));
        apb_write(REG_MATRIX_ROW_2, pack3(0, 0, 16384));
        apb_write(REG_AXIS_POINT, pack3(100, -200, 50));
        apb_write(REG_AXIS_DIRECTION, pack3(0, 0, 16384));
        add_item(1000, 0, 0, 100, -200, 50);
        add_item(0, 1000, 0, 1100, -200, 777);
        add_item(32767, -32768, 5, 32767, -32768, -32768);
        add_item(-32768, -32768, -32768, -32768, 32767, 0);
        add_item(123, -456, 789, -1000, 2000, -3000);
        add_item(-32768, 0, 0, 0, -32768, 0);
        wait_idle();

        // A matrix that is no rotation, an axis that is not unit length, upper data bits set,
        // and a write to an address past the register list.
        apb_write(REG_MATRIX_ROW_0, pack3(32767, 32767, 32767) | 64'hFFFF_0000_0000_0000);
        apb_write(REG_MATRIX_ROW_1, pack3(-32768, -32768, -32768) | 64'hA5A5_0000_0000_0000);
        apb_write(REG_MATRIX_ROW_2, pack3(32767, -32768, 0));
        apb_write(REG_AXIS_POINT, pack3(32767, -32768, 0));
        apb_write(REG_AXIS_DIRECTION, pack3(-32768, -32768, -32768));
        apb_write(UNMAPPED_IDX, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(0, 0, 0, 0, 0, 0);
        add_item(32767, 32767, 32767, 32767, 32767, 32767);
        add_item(-32768, -32768, -32768, -32768, -32768, -32768);
        add_item(32767, -32768, 1, -32768, 32767, -1);
        add_item(1, 2, 3, 4, 5, 6);
        add_item(-1, -2, -3, -4, -5, -6);
        wait_idle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 62; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            for (int chunk = 0; chunk < 5; chunk++) begin
                wait_idle();
                load_random_config();
                for (int k = 0; k < CHUNK_ITEMS; k++) begin
                    add_item(rand_coord(), rand_coord(), rand_coord(),
                             rand_coord(), rand_coord(), rand_coord());
                end
                if (phase == 1 && chunk == 2) begin
                    do @(negedge i_clk); while (pending_items.size() > CHUNK_ITEMS / 2);
                    sender_hold = 1'b1;
                    do @(negedge i_clk); while (in_ch.valid || expected_results.size() != 0);
                    sender_hold = 1'b0;
                end
            end
        end

        do @(negedge i_clk);
        while (pending_items.size() != 0 || in_ch.valid || expected_results.size() != 0);
        repeat (2 * NUM_STG) @(posedge i_clk);

        $display("Covered %0d input beats and %0d result beats, %0d of them with overflow,",
                 items_accepted, results_checked, overflow_results);
        $display("across %0d random register sets, three fixed ones and four idle patterns.",
                 config_sets);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== rotate_vector_and_point_about_axis.f =====
src/rvpa_pkg.sv
src/rvpa_in_if.sv
src/rvpa_out_if.sv
src/rotate_vector_and_point_about_axis.sv
test/tb.sv
